// File: rtl/core/fsk_ecr_pkg.sv
// Shared types, constants and register codes of the FSK edge-count receiver.
package fsk_ecr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned IDX_W      = 16;

  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Register values after reset
  localparam logic [TICK_W-1:0] WINDOW_LEN_RST = 24'd80000;
  localparam logic [CNT_W-1:0]  IDLE_LOW_RST   = 32'd320000;
  localparam logic [IDX_W-1:0]  SPF_RST        = 16'd1;

  localparam logic STATUS_SYMBOL  = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_ARMED,
    PH_CAPTURE
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN        = 3'd0,
    CFG_ARM_LOW_LEN       = 3'd1,
    CFG_EXPECTED_ZERO     = 3'd2,
    CFG_EXPECTED_ONE      = 3'd3,
    CFG_WAIT_LIMIT        = 3'd4,
    CFG_SYMBOLS_PER_FRAME = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic line_level;
    logic start_request;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [EDGE_W-1:0] edge_count;
    logic              bit_value;
    logic [IDX_W-1:0]  symbol_number;
    logic              last_symbol;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] window_len;
    logic [CNT_W-1:0]  arm_low_len;
    logic [EDGE_W-1:0] expected_edges_zero;
    logic [EDGE_W-1:0] expected_edges_one;
    logic [CNT_W-1:0]  wait_limit;
    logic [IDX_W-1:0]  symbols_per_frame;
  } cfg_t;

endpackage

// File: rtl/core/fsk_ecr_if.sv
// Channel interfaces: line sample input, result output and register write.
interface fsk_ecr_in_if;
  import fsk_ecr_pkg::*;
  logic valid;
  logic ready;
  logic line_level;
  logic start_request;
  modport source (output valid, line_level, start_request, input ready);
  modport sink (input valid, line_level, start_request, output ready);
endinterface

interface fsk_ecr_out_if;
  import fsk_ecr_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [EDGE_W-1:0] edge_count;
  logic              bit_value;
  logic [IDX_W-1:0]  symbol_number;
  logic              last_symbol;
  modport source (output valid, status, edge_count, bit_value, symbol_number, last_symbol,
                  input ready);
  modport sink (input valid, status, edge_count, bit_value, symbol_number, last_symbol,
                output ready);
endinterface

interface fsk_ecr_cfg_if;
  import fsk_ecr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/fsk_ecr_cfg.sv
// Configuration register file of the FSK edge-count receiver.
module fsk_ecr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_valid_i,
  output logic                               wr_ready_o,
  input  logic [fsk_ecr_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [fsk_ecr_pkg::CFG_DATA_W-1:0] wr_data_i,
  output fsk_ecr_pkg::cfg_t                  cfg_o
);
  import fsk_ecr_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes always taken; unknown indexes dropped
  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_WINDOW_LEN:        cfg_d.window_len          = wr_data_i[TICK_W-1:0];
        CFG_ARM_LOW_LEN:       cfg_d.arm_low_len         = wr_data_i[CNT_W-1:0];
        CFG_EXPECTED_ZERO:     cfg_d.expected_edges_zero = wr_data_i[EDGE_W-1:0];
        CFG_EXPECTED_ONE:      cfg_d.expected_edges_one  = wr_data_i[EDGE_W-1:0];
        CFG_WAIT_LIMIT:        cfg_d.wait_limit          = wr_data_i[CNT_W-1:0];
        CFG_SYMBOLS_PER_FRAME: cfg_d.symbols_per_frame   = wr_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len          <= WINDOW_LEN_RST;
      cfg_q.arm_low_len         <= IDLE_LOW_RST;
      cfg_q.expected_edges_zero <= '0;
      cfg_q.expected_edges_one  <= '0;
      cfg_q.wait_limit          <= '0;
      cfg_q.symbols_per_frame   <= SPF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/fsk_ecr_core.sv
// Sample register, receiver state and per-sample decode logic.
module fsk_ecr_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fsk_ecr_pkg::cfg_t      cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fsk_ecr_pkg::in_item_t  in_item_i,
  input  logic                   room_i,
  output logic                   push_o,
  output fsk_ecr_pkg::result_t   res_o
);
  import fsk_ecr_pkg::*;

  // Input register
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     fire;

  // Receiver state
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]  wait_q, wait_d;
  logic              prev_q, prev_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [EDGE_W-1:0] edges_q, edges_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // Step intermediates
  logic [TICK_W-1:0] len;
  logic [IDX_W-1:0]  spf;
  logic              lvl, req;
  logic              timed_out, is_cap, do_adv;
  logic [CNT_W-1:0]  wait_inc, low_inc;
  logic [EDGE_W-1:0] edges_upd, edges_b, d_one, d_zero;
  logic [TICK_W-1:0] tick_b, tick_n;
  logic [IDX_W-1:0]  idx_b;
  logic              win_end, bit_v, last_v;

  // A sample steps when the result buffer can take a word
  assign fire       = s1_valid_q && room_i;
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  // Window arithmetic
  always_comb begin
    len       = (cfg_i.window_len == '0) ? TICK_W'(1) : cfg_i.window_len;
    spf       = (cfg_i.symbols_per_frame == '0) ? IDX_W'(1) : cfg_i.symbols_per_frame;
    lvl       = s1_item_q.line_level;
    req       = s1_item_q.start_request;
    timed_out = (cfg_i.wait_limit != '0) && (wait_q >= cfg_i.wait_limit);
    wait_inc  = (wait_q == CNT_MAX) ? wait_q : wait_q + CNT_W'(1);
    low_inc   = (low_q == CNT_MAX) ? low_q : low_q + CNT_W'(1);

    // first tick of a window only takes the reference level
    edges_upd = edges_q;
    if ((tick_q != '0) && (lvl != prev_q) && (edges_q != EDGE_MAX)) begin
      edges_upd = edges_q + EDGE_W'(1);
    end

    // frame start opens a fresh window
    is_cap  = (phase_q == PH_CAPTURE);
    tick_b  = is_cap ? tick_q : '0;
    edges_b = is_cap ? edges_upd : '0;
    idx_b   = is_cap ? idx_q : '0;
    tick_n  = tick_b + TICK_W'(1);
    win_end = (tick_n >= len);

    d_one  = (edges_b > cfg_i.expected_edges_one) ? edges_b - cfg_i.expected_edges_one
                                                  : cfg_i.expected_edges_one - edges_b;
    d_zero = (edges_b > cfg_i.expected_edges_zero) ? edges_b - cfg_i.expected_edges_zero
                                                   : cfg_i.expected_edges_zero - edges_b;
    bit_v  = (d_one < d_zero);
    last_v = (({1'b0, idx_b} + (IDX_W + 1)'(1)) >= {1'b0, spf});
  end

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    low_d   = low_q;
    wait_d  = wait_q;
    prev_d  = prev_q;
    tick_d  = tick_q;
    edges_d = edges_q;
    idx_d   = idx_q;
    push_o  = 1'b0;
    res_o   = '0;
    do_adv  = 1'b0;

    if (fire) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (req) begin
            phase_d = PH_WAIT;
            low_d   = '0;
            wait_d  = '0;
            prev_d  = lvl;
          end
        end
        PH_CAPTURE: begin
          prev_d = lvl;
          do_adv = 1'b1;
        end
        PH_WAIT, PH_ARMED: begin
          if (timed_out) begin
            push_o            = 1'b1;
            res_o.status      = STATUS_TIMEOUT;
            res_o.last_symbol = 1'b1;
            phase_d           = PH_IDLE;
          end else begin
            wait_d = wait_inc;
            prev_d = lvl;
            if (phase_q == PH_WAIT) begin
              if (!lvl) begin
                low_d = low_inc;
                if (low_inc >= cfg_i.arm_low_len) begin
                  phase_d = PH_ARMED;
                end
              end else begin
                low_d = '0;
              end
            end else if (!prev_q && lvl) begin
              phase_d = PH_CAPTURE;
              do_adv  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // window advance, shared by capture and frame start
    if (do_adv) begin
      if (!win_end) begin
        tick_d  = tick_n;
        edges_d = edges_b;
        idx_d   = idx_b;
      end else begin
        push_o              = 1'b1;
        res_o.status        = STATUS_SYMBOL;
        res_o.edge_count    = edges_b;
        res_o.bit_value     = bit_v;
        res_o.symbol_number = idx_b;
        res_o.last_symbol   = last_v;
        tick_d              = '0;
        edges_d             = '0;
        idx_d               = idx_b + IDX_W'(1);
        if (last_v) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      low_q   <= '0;
      wait_q  <= '0;
      prev_q  <= 1'b0;
      tick_q  <= '0;
      edges_q <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      low_q   <= low_d;
      wait_q  <= wait_d;
      prev_q  <= prev_d;
      tick_q  <= tick_d;
      edges_q <= edges_d;
      idx_q   <= idx_d;
    end
  end

  // A timeout word always leaves the receiver idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.status == STATUS_TIMEOUT) |=> (phase_q == PH_IDLE))
    else $error("timeout did not return to idle");

  // Window position stays inside the window while capturing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CAPTURE) |-> (tick_q < len))
    else $error("window tick beyond window length");

  // Symbol index stays inside the frame while capturing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CAPTURE) |-> (idx_q < spf))
    else $error("symbol index beyond frame length");

endmodule

// File: rtl/core/fsk_ecr_out_buf.sv
// Two-word result buffer between the decode logic and the output channel.
module fsk_ecr_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fsk_ecr_pkg::result_t push_data_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fsk_ecr_pkg::result_t out_data_o
);
  import fsk_ecr_pkg::*;

  result_t    head_q, tail_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q != 2'd2) || pop;
  assign out_data_o  = head_q;

  // Word count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Word storage: head is the word on offer
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd1) begin
        head_q <= push_data_i;
      end else begin
        head_q <= tail_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        tail_q <= push_data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= push_data_i;
      end else begin
        tail_q <= push_data_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |-> !push_i)
    else $error("push into full result buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && pop && !push_i) |=> (head_q == $past(tail_q)))
    else $error("second word lost on drain");

endmodule

// File: rtl/core/fsk_edge_count_receiver.sv
// Top level of the FSK edge-count receiver: registers, decode and result buffer.
// Path: a result word passes the input register, then the result buffer; a sample
//   waits in the input register while the buffer is full.
// Throughput: one sample per cycle while the result buffer has room; the per-sample
// decode is one registered pass; the two-word buffer absorbs sink stalls until full.
// Reset (rst_ni low, asynchronous): idle, counters cleared, registers at defaults.
module fsk_edge_count_receiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  fsk_ecr_in_if.sink    in_i,
  fsk_ecr_out_if.source out_o,
  fsk_ecr_cfg_if.sink   cfg_i
);
  import fsk_ecr_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  result_t  push_data, out_data;
  logic     push, room;

  fsk_ecr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  assign in_item.line_level    = in_i.line_level;
  assign in_item.start_request = in_i.start_request;

  fsk_ecr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .room_i     (room),
    .push_o     (push),
    .res_o      (push_data)
  );

  fsk_ecr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.status        = out_data.status;
  assign out_o.edge_count    = out_data.edge_count;
  assign out_o.bit_value     = out_data.bit_value;
  assign out_o.symbol_number = out_data.symbol_number;
  assign out_o.last_symbol   = out_data.last_symbol;

endmodule
